[design/ltkm_pkg.sv]
// shared codes and defaults for the loser tree merge unit
package ltkm_pkg;

  localparam int DEF_WAYS      = 8;
  localparam int DEF_WAY_DEPTH = 512;

  localparam int VALUE_W  = 32;
  localparam int WAY_W    = 3;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

endpackage

[design/loser_tree_kway_merge_unit.sv]
// loser tree k-way merge unit: list storage, tree build and replay sequencer
//
// Usage:
//   One request channel (in_valid/in_stall with in_op, in_way, in_value) and one
//   result channel (out_valid/out_stall with out_value, out_way, out_status).
//   A request moves when valid is high and stall is low. Every request yields
//   exactly one result, in request order.
//   Load, clear and the unused opcode finish in the accepting cycle; the result
//   is registered and valid in the next cycle. A pop on a built tree keeps the
//   block busy while it does one list read for the new head of the popped way,
//   then one loser node read and one compare per level. The first pop after a
//   load or clear first builds the tree: a head fetch per leaf, then a read of
//   both children and a compare per internal node, all through the single
//   comparator and the single read port of each store.
//   The result register holds its item while out_stall is high; a new request
//   is taken only once that register is free or being emptied.
//   Synchronous reset (rst_n low) empties all lists, drops the tree and the
//   pending result. List storage itself is not cleared and needs no sweep.
module loser_tree_kway_merge_unit #(
  parameter int WAYS      = ltkm_pkg::DEF_WAYS,
  parameter int WAY_DEPTH = ltkm_pkg::DEF_WAY_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ltkm_pkg::OP_W-1:0]       in_op,
  input  logic [ltkm_pkg::WAY_W-1:0]      in_way,
  input  logic [ltkm_pkg::VALUE_W-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ltkm_pkg::VALUE_W-1:0]    out_value,
  output logic [ltkm_pkg::WAY_W-1:0]      out_way,
  output logic [ltkm_pkg::STATUS_W-1:0]   out_status
);

  localparam int LW    = $clog2(WAYS);
  localparam int LS    = 1 << LW;
  localparam int CW    = $clog2(WAY_DEPTH + 1);
  localparam int DEPTH = WAYS * WAY_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW    = ltkm_pkg::VALUE_W;

  typedef struct packed {
    logic          ex;
    logic [LW-1:0] idx;
    logic [VW-1:0] val;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BLRD, S_BLWR, S_BNA, S_BNB, S_BCMP, S_POP, S_PRD, S_PWR, S_RRD, S_RCMP
  } state_t;

  function automatic logic wins(entry_t a, entry_t b);
    logic r;
    if (a.ex != b.ex) begin
      r = b.ex;
    end else if (!a.ex && (a.val != b.val)) begin
      r = a.val < b.val;
    end else begin
      r = a.idx > b.idx;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [LW-1:0] leaf, logic [CW-1:0] cnt);
    logic [31:0] full;
    full = 32'(leaf) * 32'(WAY_DEPTH) + 32'(cnt);
    return full[AW-1:0];
  endfunction

  // memories
  logic [VW-1:0] store_mem [DEPTH];
  entry_t        win_mem   [2*LS];
  entry_t        loser_mem [LS];

  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [VW-1:0] st_q;
  logic          wn_we, wn_re;
  logic [LW:0]   wn_waddr, wn_raddr;
  entry_t        wn_wdata, wn_q;
  logic          ls_we, ls_re;
  logic [LW-1:0] ls_waddr, ls_raddr;
  entry_t        ls_wdata, ls_q;

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= in_value;
    if (st_re) st_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (wn_we) win_mem[wn_waddr] <= wn_wdata;
    if (wn_re) wn_q <= win_mem[wn_raddr];
  end

  always_ff @(posedge clk) begin
    if (ls_we) loser_mem[ls_waddr] <= ls_wdata;
    if (ls_re) ls_q <= loser_mem[ls_raddr];
  end

  // registers
  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 fill_r [LS];
  logic [CW-1:0]                 fill_nxt [LS];
  logic [CW-1:0]                 rd_r [LS];
  logic [CW-1:0]                 rd_nxt [LS];
  logic                          built_r, built_nxt;
  logic [LW-1:0]                 node_r, node_nxt;
  logic                          lex_r, lex_nxt;
  entry_t                        a_r, a_nxt;
  entry_t                        cand_r, cand_nxt;
  entry_t                        top_r, top_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [VW-1:0]                 out_value_r, out_value_nxt;
  logic [ltkm_pkg::WAY_W-1:0]    out_way_r, out_way_nxt;
  logic [ltkm_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic          accept;
  logic [LW-1:0] in_leaf;
  logic          way_bad;
  entry_t        cmp_b, win_e, lose_e;
  logic          a_wins;

  assign in_stall   = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign in_leaf    = LW'(in_way);
  assign way_bad    = (32'(in_way) >= 32'(WAYS)) || (fill_r[in_leaf] == CW'(WAY_DEPTH));
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_way    = out_way_r;
  assign out_status = out_status_r;

  // shared comparator: build pairs a_r against a fetched winner, replay a loser against cand_r
  always_comb begin
    cmp_b = (state_r == S_BCMP) ? wn_q : cand_r;
    if (state_r == S_BCMP) begin
      a_wins = wins(a_r, cmp_b);
    end else begin
      a_wins = wins(ls_q, cmp_b);
    end
    win_e  = a_wins ? a_r : cmp_b;
    lose_e = a_wins ? cmp_b : a_r;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    rd_nxt         = rd_r;
    built_nxt      = built_r;
    node_nxt       = node_r;
    lex_nxt        = lex_r;
    a_nxt          = a_r;
    cand_nxt       = cand_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_way_nxt    = out_way_r;
    out_status_nxt = out_status_r;
    st_we    = 1'b0;
    st_waddr = addr_of(in_leaf, fill_r[in_leaf]);
    st_re    = 1'b0;
    st_raddr = addr_of(node_r, rd_r[node_r]);
    wn_we    = 1'b0;
    wn_waddr = {1'b1, node_r};
    wn_wdata = '0;
    wn_re    = 1'b0;
    wn_raddr = {node_r, 1'b0};
    ls_we    = 1'b0;
    ls_waddr = node_r;
    ls_wdata = lose_e;
    ls_re    = 1'b0;
    ls_raddr = node_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_value_nxt  = '0;
          out_way_nxt    = '0;
          out_status_nxt = ltkm_pkg::ST_OK;
          case (in_op)
            ltkm_pkg::OP_LOAD: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = in_value;
              out_way_nxt   = in_way;
              if (way_bad) begin
                out_status_nxt = ltkm_pkg::ST_FULL;
              end else begin
                st_we             = 1'b1;
                fill_nxt[in_leaf] = fill_r[in_leaf] + CW'(1);
                built_nxt         = 1'b0;
              end
            end
            ltkm_pkg::OP_POP: begin
              if (built_r) begin
                state_nxt = S_POP;
              end else begin
                node_nxt  = '0;
                state_nxt = S_BLRD;
              end
            end
            ltkm_pkg::OP_CLEAR: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ltkm_pkg::ST_CLEARED;
              built_nxt      = 1'b0;
              for (int i = 0; i < LS; i++) begin
                fill_nxt[i] = '0;
                rd_nxt[i]   = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_BLRD: begin
        st_re     = 1'b1;
        lex_nxt   = rd_r[node_r] >= fill_r[node_r];
        state_nxt = S_BLWR;
      end
      S_BLWR: begin
        wn_we    = 1'b1;
        wn_waddr = {1'b1, node_r};
        wn_wdata = '{ex: lex_r, idx: node_r, val: st_q};
        if (node_r == LW'(LS - 1)) begin
          state_nxt = S_BNA;
        end else begin
          node_nxt  = node_r + LW'(1);
          state_nxt = S_BLRD;
        end
      end
      S_BNA: begin
        wn_re     = 1'b1;
        wn_raddr  = {node_r, 1'b0};
        state_nxt = S_BNB;
      end
      S_BNB: begin
        a_nxt     = wn_q;
        wn_re     = 1'b1;
        wn_raddr  = {node_r, 1'b1};
        state_nxt = S_BCMP;
      end
      S_BCMP: begin
        wn_we    = 1'b1;
        wn_waddr = {1'b0, node_r};
        wn_wdata = win_e;
        ls_we    = 1'b1;
        ls_waddr = node_r;
        ls_wdata = lose_e;
        if (node_r == LW'(1)) begin
          top_nxt   = win_e;
          built_nxt = 1'b1;
          state_nxt = S_POP;
        end else begin
          node_nxt  = node_r - LW'(1);
          state_nxt = S_BNA;
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        if (top_r.ex) begin
          out_value_nxt  = '0;
          out_way_nxt    = '0;
          out_status_nxt = ltkm_pkg::ST_EMPTY;
          state_nxt      = S_IDLE;
        end else begin
          out_value_nxt     = top_r.val;
          out_way_nxt       = ltkm_pkg::WAY_W'(top_r.idx);
          out_status_nxt    = ltkm_pkg::ST_OK;
          rd_nxt[top_r.idx] = rd_r[top_r.idx] + CW'(1);
          cand_nxt          = top_r;
          state_nxt         = S_PRD;
        end
      end
      S_PRD: begin
        st_re       = 1'b1;
        st_raddr    = addr_of(cand_r.idx, rd_r[cand_r.idx]);
        cand_nxt.ex = rd_r[cand_r.idx] >= fill_r[cand_r.idx];
        state_nxt   = S_PWR;
      end
      S_PWR: begin
        cand_nxt.val = st_q;
        node_nxt     = LW'((LW+1)'(LS) + (LW+1)'(cand_r.idx) >> 1);
        state_nxt    = S_RRD;
      end
      S_RRD: begin
        ls_re     = 1'b1;
        ls_raddr  = node_r;
        state_nxt = S_RCMP;
      end
      S_RCMP: begin
        if (a_wins) begin
          ls_we    = 1'b1;
          ls_waddr = node_r;
          ls_wdata = cand_r;
          cand_nxt = ls_q;
        end
        if (node_r == LW'(1)) begin
          top_nxt   = a_wins ? ls_q : cand_r;
          state_nxt = S_IDLE;
        end else begin
          node_nxt  = node_r >> 1;
          state_nxt = S_RRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LS; i++) begin
        fill_r[i] <= '0;
        rd_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      rd_r        <= rd_nxt;
    end
    node_r       <= node_nxt;
    lex_r        <= lex_nxt;
    a_r          <= a_nxt;
    cand_r       <= cand_nxt;
    top_r        <= top_nxt;
    out_value_r  <= out_value_nxt;
    out_way_r    <= out_way_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

[tb/tb_loser_tree_kway_merge_unit.sv]
`timescale 1ns / 1ps
// loser tree merge testbench: directed table, random merge traffic, way overflow
module tb_loser_tree_kway_merge_unit;

  localparam int NUM_WAYS     = ltkm_pkg::DEF_WAYS;
  localparam int LIST_DEPTH   = ltkm_pkg::DEF_WAY_DEPTH;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 100;
  localparam int DIR_ROWS     = 25;

  localparam logic [ltkm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ltkm_pkg::VALUE_W-1:0]  value;
    logic [ltkm_pkg::WAY_W-1:0]    way;
    logic [ltkm_pkg::STATUS_W-1:0] status;
  } merge_result_t;

  typedef struct {
    logic [ltkm_pkg::OP_W-1:0]    op;
    logic [ltkm_pkg::WAY_W-1:0]   way;
    logic [ltkm_pkg::VALUE_W-1:0] value;
    bit                           typed;
    merge_result_t                res;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [ltkm_pkg::OP_W-1:0]     in_op;
  logic [ltkm_pkg::WAY_W-1:0]    in_way;
  logic [ltkm_pkg::VALUE_W-1:0]  in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [ltkm_pkg::VALUE_W-1:0]  out_value;
  logic [ltkm_pkg::WAY_W-1:0]    out_way;
  logic [ltkm_pkg::STATUS_W-1:0] out_status;

  // predicted merge state
  logic [ltkm_pkg::VALUE_W-1:0] list_mem [NUM_WAYS][LIST_DEPTH];
  int unsigned                  fill_cnt [NUM_WAYS];
  int unsigned                  pop_idx  [NUM_WAYS];

  merge_result_t pending_results[$];
  int            err_count   = 0;
  int            cycle_count = 0;
  int            tx_pct      = 0;
  int            rx_pct      = 0;
  bit            hold_ask    = 1'b0;
  bit            hold_ack    = 1'b0;
  int            hold_left   = 0;

  stim_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b1,
      {32'h0000_0000, 3'd0, ltkm_pkg::ST_EMPTY}},
    '{OP_UNUSED,           3'd7, 32'hFFFF_FFFF, 1'b1,
      {32'h0000_0000, 3'd0, ltkm_pkg::ST_OK}},
    '{ltkm_pkg::OP_LOAD,   3'd0, 32'h0000_0000, 1'b1,
      {32'h0000_0000, 3'd0, ltkm_pkg::ST_OK}},
    '{ltkm_pkg::OP_LOAD,   3'd7, 32'hFFFF_FFFF, 1'b1,
      {32'hFFFF_FFFF, 3'd7, ltkm_pkg::ST_OK}},
    '{ltkm_pkg::OP_LOAD,   3'd3, 32'h0000_0005, 1'b0, '0},
    '{ltkm_pkg::OP_LOAD,   3'd5, 32'h0000_0005, 1'b0, '0},
    '{ltkm_pkg::OP_LOAD,   3'd3, 32'h0000_0005, 1'b0, '0},
    '{ltkm_pkg::OP_LOAD,   3'd1, 32'h8000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_LOAD,   3'd6, 32'h7FFF_FFFF, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd7, 32'hFFFF_FFFF, 1'b0, '0},
    '{ltkm_pkg::OP_LOAD,   3'd0, 32'h0000_0002, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd2, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_LOAD,   3'd2, 32'h0000_0001, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{ltkm_pkg::OP_POP,    3'd5, 32'h0000_0000, 1'b1,
      {32'h0000_0000, 3'd0, ltkm_pkg::ST_EMPTY}},
    '{ltkm_pkg::OP_LOAD,   3'd4, 32'h0000_ABCD, 1'b0, '0},
    '{ltkm_pkg::OP_CLEAR,  3'd6, 32'h1234_5678, 1'b1,
      {32'h0000_0000, 3'd0, ltkm_pkg::ST_CLEARED}},
    '{ltkm_pkg::OP_POP,    3'd0, 32'h0000_0000, 1'b1,
      {32'h0000_0000, 3'd0, ltkm_pkg::ST_EMPTY}},
    '{ltkm_pkg::OP_LOAD,   3'd2, 32'hAAAA_AAAA, 1'b0, '0}
  };

  loser_tree_kway_merge_unit #(
    .WAYS      (NUM_WAYS),
    .WAY_DEPTH (LIST_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_way     (in_way),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_way    (out_way),
    .out_status (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // smallest unread head wins, ties to the higher way
  task automatic predict_merge(input logic [ltkm_pkg::OP_W-1:0] op,
                               input logic [ltkm_pkg::WAY_W-1:0] way,
                               input logic [ltkm_pkg::VALUE_W-1:0] value,
                               output merge_result_t res);
    int best;
    res  = '0;
    best = -1;
    case (op)
      ltkm_pkg::OP_LOAD: begin
        res.value = value;
        res.way   = way;
        if (way >= NUM_WAYS || fill_cnt[way] >= LIST_DEPTH) begin
          res.status = ltkm_pkg::ST_FULL;
        end else begin
          list_mem[way][fill_cnt[way]] = value;
          fill_cnt[way]++;
        end
      end
      ltkm_pkg::OP_POP: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (pop_idx[w] < fill_cnt[w]) begin
            if (best < 0 || list_mem[w][pop_idx[w]] <= list_mem[best][pop_idx[best]]) begin
              best = w;
            end
          end
        end
        if (best < 0) begin
          res.status = ltkm_pkg::ST_EMPTY;
        end else begin
          res.value = list_mem[best][pop_idx[best]];
          res.way   = ltkm_pkg::WAY_W'(best);
          pop_idx[best]++;
        end
      end
      ltkm_pkg::OP_CLEAR: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          fill_cnt[w] = 0;
          pop_idx[w]  = 0;
        end
        res.status = ltkm_pkg::ST_CLEARED;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [ltkm_pkg::OP_W-1:0] op,
                              input logic [ltkm_pkg::WAY_W-1:0] way,
                              input logic [ltkm_pkg::VALUE_W-1:0] value,
                              input bit typed = 1'b0,
                              input merge_result_t typed_res = '0);
    merge_result_t res;
    bit            taken;
    while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_way   <= way;
    in_value <= value;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_merge(op, way, value, res);
    if (typed) begin
      res = typed_res;
    end
    pending_results = {pending_results, res};
  endtask

  task automatic run_traffic(input int budget);
    int                           issued;
    int                           kind;
    int                           total;
    int                           left;
    int                           w;
    int                           want     [NUM_WAYS];
    logic [ltkm_pkg::VALUE_W-1:0] last_val [NUM_WAYS];
    logic [ltkm_pkg::VALUE_W-1:0] span;
    logic [ltkm_pkg::VALUE_W:0]   sum;
    issued = 0;
    while (issued < budget) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        // ascending lists spread over random ways, then drained
        total = 0;
        span  = $urandom_range(1) ? ltkm_pkg::VALUE_W'($urandom_range(0, 3)) : $urandom;
        for (w = 0; w < NUM_WAYS; w++) begin
          want[w]     = ($urandom_range(99) < 60) ? $urandom_range(0, 6) : 0;
          last_val[w] = $urandom_range(1) ? ltkm_pkg::VALUE_W'($urandom_range(0, 20))
                                          : $urandom;
          total       += want[w];
        end
        left = total;
        while (left > 0) begin
          w = $urandom_range(NUM_WAYS - 1);
          if (want[w] > 0) begin
            want[w]--;
            left--;
            sum         = {1'b0, last_val[w]} + span;
            last_val[w] = sum[ltkm_pkg::VALUE_W] ? '1 : sum[ltkm_pkg::VALUE_W-1:0];
            send_request(ltkm_pkg::OP_LOAD, ltkm_pkg::WAY_W'(w), last_val[w]);
            issued++;
          end
        end
        repeat (total + $urandom_range(0, 2)) begin
          send_request(ltkm_pkg::OP_POP, ltkm_pkg::WAY_W'($urandom), $urandom);
          issued++;
        end
        if ($urandom_range(1)) begin
          send_request(ltkm_pkg::OP_CLEAR, ltkm_pkg::WAY_W'($urandom), $urandom);
          issued++;
        end
      end else if (kind < 85) begin
        // loads landing between pops
        repeat ($urandom_range(4, 12)) begin
          send_request($urandom_range(1) ? ltkm_pkg::OP_LOAD : ltkm_pkg::OP_POP,
                       ltkm_pkg::WAY_W'($urandom),
                       $urandom_range(1) ? ltkm_pkg::VALUE_W'($urandom_range(0, 7))
                                         : $urandom);
          issued++;
        end
      end else begin
        send_request(ltkm_pkg::OP_W'($urandom_range(3)), ltkm_pkg::WAY_W'($urandom),
                     $urandom);
        issued++;
      end
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_ack) begin
        hold_ack  = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
      end
    end
  end

  always @(negedge clk) begin : check_results
    merge_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %h way %0d status %0d", $time,
                 out_value, out_way, out_status);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) begin
          $display("%0t: out_value expected %h got %h", $time, exp_res.value, out_value);
          err_count++;
        end
        if (out_way !== exp_res.way) begin
          $display("%0t: out_way expected %0d got %0d", $time, exp_res.way, out_way);
          err_count++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: out_status expected %0d got %0d", $time, exp_res.status,
                   out_status);
          err_count++;
        end
      end
    end
  end

  initial begin
    logic [ltkm_pkg::WAY_W-1:0]   full_way;
    logic [ltkm_pkg::VALUE_W-1:0] full_val;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_op    <= ltkm_pkg::OP_LOAD;
    in_way   <= '0;
    in_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_rows[i].op, dir_rows[i].way, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].res);
    end

    run_traffic(PHASE_ITEMS);
    tx_pct = 60;
    run_traffic(PHASE_ITEMS);
    tx_pct = 0;
    rx_pct = 60;
    // long receiver hold while requests keep coming
    hold_ask <= ~hold_ask;
    run_traffic(PHASE_ITEMS);
    tx_pct = 31;
    rx_pct = 31;
    run_traffic(PHASE_ITEMS);

    // fill one way to the brim, overflow it, pop some, overflow again
    full_way = ltkm_pkg::WAY_W'($urandom);
    full_val = ltkm_pkg::VALUE_W'($urandom_range(0, 1000));
    send_request(ltkm_pkg::OP_CLEAR, full_way, $urandom);
    while (fill_cnt[full_way] < LIST_DEPTH) begin
      full_val = full_val + ltkm_pkg::VALUE_W'($urandom_range(0, 100000));
      send_request(ltkm_pkg::OP_LOAD, full_way, full_val);
    end
    repeat (2) send_request(ltkm_pkg::OP_LOAD, full_way, $urandom);
    repeat (16) send_request(ltkm_pkg::OP_POP, ltkm_pkg::WAY_W'($urandom), $urandom);
    send_request(ltkm_pkg::OP_LOAD, full_way, $urandom);
    send_request(ltkm_pkg::OP_CLEAR, ltkm_pkg::WAY_W'($urandom), $urandom);
    in_valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
